// ===== rtl/arx_model_filter_macros.svh =====
// Assertion macros for the RTL of the ARX filter.
`ifndef ARX_MODEL_FILTER_MACROS_SVH
`define ARX_MODEL_FILTER_MACROS_SVH

// Property that holds in the same cycle, sampled on clk_i, off during reset.
`define ARX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the trigger.
`define ARX_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/arx_pkg.sv =====
// Types, constants and register map of the ARX filter.
`default_nettype none
package arx_pkg;

  localparam int unsigned A_ORDER    = 3;
  localparam int unsigned B_ORDER    = 3;
  localparam int unsigned MAX_DELAY  = 7;
  // Stored past inputs; the newest sample u[n] sits in the input register.
  localparam int unsigned HIST_DEPTH = MAX_DELAY + B_ORDER - 1;
  localparam int unsigned TAP_COUNT  = HIST_DEPTH + 1;
  localparam int unsigned TAP_W      = $clog2(TAP_COUNT);
  localparam int unsigned DELAY_W    = 3;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W    = PROD_W + 4;   // B_ORDER + 1 + A_ORDER products

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [DELAY_W-1:0]         delay_t;

  typedef enum logic [2:0] {
    REG_A_COEF_1    = 3'd0,
    REG_A_COEF_2    = 3'd1,
    REG_A_COEF_3    = 3'd2,
    REG_B_COEF_0    = 3'd3,
    REG_B_COEF_1    = 3'd4,
    REG_B_COEF_2    = 3'd5,
    REG_INPUT_DELAY = 3'd6,
    REG_DIRECT_GAIN = 3'd7
  } arx_reg_e;

  localparam coef_t  A_COEF_1_RST    = -16'sd2458;   // -0.6
  localparam coef_t  B_COEF_0_RST    = 16'sd1638;    // 0.4
  localparam delay_t INPUT_DELAY_RST = 3'd1;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = -16'sh8000;

endpackage
`default_nettype wire

// ===== rtl/arx_in_if.sv =====
// Input sample channel: valid/ready plus one sample.
`default_nettype none
interface arx_in_if;
  import arx_pkg::*;

  logic    valid;
  logic    ready;
  sample_t in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/arx_out_if.sv =====
// Output sample channel: valid/ready plus sample and clip flag.
`default_nettype none
interface arx_out_if;
  import arx_pkg::*;

  logic    valid;
  logic    ready;
  sample_t out_sample;
  logic    saturated;

  modport source (output valid, output out_sample, output saturated, input ready);
  modport sink   (input valid, input out_sample, input saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/arx_model_filter.sv =====
// ARX difference-equation IIR filter: input register, combinational datapath, output register.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------
//   in_i     | in  | valid / ready      | in_sample (s16)
//   out_o    | out | valid / ready      | out_sample (s16), saturated
//   apb      | in  | psel/penable/pwrite| 8 regs at 4*i, 32-bit data
//
// One beat in and one beat out per cycle while out_o is not stalled. A taken beat
// sits in the input register; the whole equation (seven products, sum, round,
// saturate) is evaluated from it combinationally and lands in the output
// register once that register is empty or being drained.
// Output history moves with the output register, closing the feedback loop
// between the two registers. in_i.ready drops only when both registers are
// full and out_o is stalled. Reset clears histories and valid bits.
`default_nettype none
`include "arx_model_filter_macros.svh"

module arx_model_filter
  import arx_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  arx_in_if.sink                 in_i,
  arx_out_if.source              out_o
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  coef_t  a_coef_q [A_ORDER];
  coef_t  b_coef_q [B_ORDER];
  coef_t  gain_q;
  delay_t delay_q;

  arx_reg_e reg_sel;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = arx_reg_e'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_coef_q[0] <= A_COEF_1_RST;
      a_coef_q[1] <= '0;
      a_coef_q[2] <= '0;
      b_coef_q[0] <= B_COEF_0_RST;
      b_coef_q[1] <= '0;
      b_coef_q[2] <= '0;
      delay_q     <= INPUT_DELAY_RST;
      gain_q      <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_A_COEF_1:    a_coef_q[0] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_A_COEF_2:    a_coef_q[1] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_A_COEF_3:    a_coef_q[2] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_B_COEF_0:    b_coef_q[0] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_B_COEF_1:    b_coef_q[1] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_B_COEF_2:    b_coef_q[2] <= coef_t'(pwdata[COEF_W-1:0]);
        REG_INPUT_DELAY: delay_q     <= pwdata[DELAY_W-1:0];
        REG_DIRECT_GAIN: gain_q      <= coef_t'(pwdata[COEF_W-1:0]);
        default:         ;
      endcase
    end
  end

  // Readback: coefficients sign-extended, delay zero-extended.
  always_comb begin
    case (reg_sel)
      REG_A_COEF_1:    prdata = APB_DW'(a_coef_q[0]);
      REG_A_COEF_2:    prdata = APB_DW'(a_coef_q[1]);
      REG_A_COEF_3:    prdata = APB_DW'(a_coef_q[2]);
      REG_B_COEF_0:    prdata = APB_DW'(b_coef_q[0]);
      REG_B_COEF_1:    prdata = APB_DW'(b_coef_q[1]);
      REG_B_COEF_2:    prdata = APB_DW'(b_coef_q[2]);
      REG_INPUT_DELAY: prdata = {{(APB_DW-DELAY_W){1'b0}}, delay_q};
      REG_DIRECT_GAIN: prdata = APB_DW'(gain_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Flow control: the input register moves into the output register
  // when the latter is empty or being drained.
  // ---------------------------------------------------------------
  logic in_vld_q, out_vld_q;
  logic step, in_acc;

  assign step       = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | step;
  assign in_acc     = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (~out_vld_q | out_o.ready) out_vld_q <= in_vld_q;
    end
  end

  // ---------------------------------------------------------------
  // Input register and input history
  // ---------------------------------------------------------------
  sample_t in_q;
  sample_t hist_q [HIST_DEPTH];   // hist_q[k] = u[n-1-k] for the beat in in_q
  sample_t taps   [TAP_COUNT];    // taps[k]   = u[n-k]

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_i.in_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist_q[k] <= '0;
      end
    end else if (step) begin
      hist_q[0] <= in_q;
      for (int k = 1; k < HIST_DEPTH; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  always_comb begin
    taps[0] = in_q;
    for (int k = 1; k < TAP_COUNT; k++) begin
      taps[k] = hist_q[k-1];
    end
  end

  // ---------------------------------------------------------------
  // Datapath: products, sum, round half up, saturate
  // ---------------------------------------------------------------
  sample_t y_hist_q [A_ORDER];    // y_hist_q[i] = y[n-1-i]
  prod_t   ff_prod  [B_ORDER+1];
  prod_t   fb_prod  [A_ORDER];
  acc_t    ff_sum, fb_sum, acc, acc_rnd;
  logic signed [ACC_W-FRAC_W-1:0] y_full;
  sample_t y_d;
  logic    sat_d;
  sample_t out_sample_q;
  logic    sat_q;

  always_comb begin
    logic [TAP_W-1:0] idx;
    for (int j = 0; j < B_ORDER; j++) begin
      idx        = TAP_W'(delay_q) + TAP_W'(j);
      ff_prod[j] = prod_t'(b_coef_q[j]) * prod_t'(taps[idx]);
    end
    ff_prod[B_ORDER] = prod_t'(gain_q) * prod_t'(in_q);
    for (int i = 0; i < A_ORDER; i++) begin
      fb_prod[i] = prod_t'(a_coef_q[i]) * prod_t'(y_hist_q[i]);
    end
    // two short sums side by side, then one subtract
    ff_sum = (ACC_W'(ff_prod[0]) + ACC_W'(ff_prod[1]))
           + (ACC_W'(ff_prod[2]) + ACC_W'(ff_prod[3]));
    fb_sum = (ACC_W'(fb_prod[0]) + ACC_W'(fb_prod[1])) + ACC_W'(fb_prod[2]);
    acc     = ff_sum - fb_sum;
    acc_rnd = acc + (acc_t'(1) <<< (FRAC_W - 1));
    y_full  = acc_rnd[ACC_W-1:FRAC_W];
    if (y_full > (ACC_W-FRAC_W)'(SAMPLE_MAX)) begin
      y_d   = SAMPLE_MAX;
      sat_d = 1'b1;
    end else if (y_full < (ACC_W-FRAC_W)'(SAMPLE_MIN)) begin
      y_d   = SAMPLE_MIN;
      sat_d = 1'b1;
    end else begin
      y_d   = y_full[SAMPLE_W-1:0];
      sat_d = 1'b0;
    end
  end

  // Output history moves with the beat entering the output register, so the
  // next beat in the input register always sees y[n-1] of its predecessor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < A_ORDER; i++) begin
        y_hist_q[i] <= '0;
      end
    end else if (step) begin
      y_hist_q[0] <= y_d;
      for (int i = 1; i < A_ORDER; i++) begin
        y_hist_q[i] <= y_hist_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_sample_q <= y_d;
      sat_q        <= sat_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_sample = out_sample_q;
  assign out_o.saturated  = sat_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `ARX_ASSERT_NEXT(a_fb_tracks_out, step, y_hist_q[0] == out_sample_q,
                   "output history out of step with output register")
  `ARX_ASSERT_NEXT(a_fb_shift, step, y_hist_q[1] == $past(y_hist_q[0]),
                   "output history did not shift")
  `ARX_ASSERT(a_sat_extreme,
              !(out_vld_q && sat_q) || out_sample_q == SAMPLE_MAX || out_sample_q == SAMPLE_MIN,
              "saturated flag on an unclipped sample")
  `ARX_ASSERT(a_ready_full, in_i.ready || (in_vld_q && out_vld_q),
              "input stalled with an empty register")
  `ARX_ASSERT_NEXT(a_hist_newest, step, hist_q[0] == $past(in_q),
                   "input history missed a beat")

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the ARX difference-equation filter.
`timescale 1ns / 100ps

module tb_top;
  import arx_pkg::*;

  // Run shape
  localparam int N_PHASES        = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_PHASE      = 2;    // output held off for a long stretch
  localparam int PAUSE_PHASE     = 5;    // input paused until all outputs are back
  localparam int HOLD_CYCLES     = 300;
  localparam int PIPE_SLACK      = 6;    // input and output registers plus margin
  localparam int QUIET_LIMIT     = 2000; // cycles with no beat on either side
  localparam int MAX_REPORTS     = 10;
  localparam int N_DIR           = 37;

  localparam coef_t COEF_MAX = 16'sh7fff;
  localparam coef_t COEF_MIN = 16'sh8000;
  localparam longint ROUND_HALF = longint'(1) << (FRAC_W - 1);

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum logic [1:0] {GAP_BOTH, GAP_SRC_ONLY, GAP_SNK_ONLY, GAP_NONE} gap_mode_e;
  typedef enum logic [1:0] {COEF_SMALL, COEF_FULL, COEF_EXTREME} coef_style_e;

  // One directed row: a register write, or a sample with an optional typed result.
  typedef struct packed {
    row_kind_e   kind;
    arx_reg_e    rsel;
    logic [31:0] val;
    logic        typed;
    sample_t     y_exp;
    logic        sat_exp;
  } stim_row_t;

  typedef struct packed {
    sample_t y;
    logic    clip;
  } out_beat_t;

  // Clock, reset and the APB side
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  arx_in_if  in_bus ();
  arx_out_if out_bus ();

  arx_model_filter i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_bus),
    .out_o   (out_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: own copy of the registers and both histories.
  coef_t   fb_coef [A_ORDER];            // a_1..a_3, applied to past outputs
  coef_t   ff_coef [B_ORDER];            // b_0..b_2, applied to delayed inputs
  delay_t  dead_time;
  coef_t   direct_coef;
  sample_t u_hist [MAX_DELAY + B_ORDER]; // entry 0 is the newest sample
  sample_t y_hist [A_ORDER];             // entry 0 is y[n-1]

  out_beat_t pending_outputs [$];

  // Shared between the driving processes
  gap_mode_e gap_mode = GAP_BOTH;
  bit        hold_req = 1'b0;
  int        fail_count = 0;
  int        n_in = 0;
  int        n_out = 0;
  int        n_clip = 0;
  int        n_settings = 0;
  int        n_holds = 0;

  // Directed stimulus. Typed results only where the answer is obvious:
  // zero right after reset, pure-gain extremes, rounding halves, delay zero.
  stim_row_t dir_rows [N_DIR] = '{
    // reset settings: delay 1, so the first outputs see only zeros
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_0000, 1'b1, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_7fff, 1'b1, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_8000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_3039, 1'b0, 16'sh0000, 1'b0},
    // direct gain only, at its positive extreme; upper data bits are junk
    '{ROW_WRITE,  REG_A_COEF_1,    32'h0000_0000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_B_COEF_0,    32'h0000_0000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_INPUT_DELAY, 32'h0000_0007, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_DIRECT_GAIN, 32'ha5a5_7fff, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_7fff, 1'b1, 16'sh7fff, 1'b1},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_8000, 1'b1, 16'sh8000, 1'b1},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_0000, 1'b1, 16'sh0000, 1'b0},
    // most negative gain (-8.0)
    '{ROW_WRITE,  REG_DIRECT_GAIN, 32'h0000_8000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_0001, 1'b1, 16'shfff8, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_8000, 1'b1, 16'sh7fff, 1'b1},
    // gain 0.5: exact halves round toward +inf
    '{ROW_WRITE,  REG_DIRECT_GAIN, 32'h0000_0800, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_0001, 1'b1, 16'sh0001, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_ffff, 1'b1, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_fffd, 1'b1, 16'shffff, 1'b0},
    // zero dead time: b_0 = 1.0 acts on the current sample
    '{ROW_WRITE,  REG_DIRECT_GAIN, 32'h0000_0000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_INPUT_DELAY, 32'hffff_fff8, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_B_COEF_0,    32'h0000_1000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_04d2, 1'b1, 16'sh04d2, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_8000, 1'b1, 16'sh8000, 1'b0},
    // full feedback and deepest taps at max delay, then a middle delay
    '{ROW_WRITE,  REG_A_COEF_1,    32'h0000_f000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_A_COEF_2,    32'h0000_7fff, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_A_COEF_3,    32'h0000_8000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_B_COEF_1,    32'h0000_7fff, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_B_COEF_2,    32'h0000_8000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_INPUT_DELAY, 32'h0000_0007, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_7fff, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_8000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_0064, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_ffff, 1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE,  REG_INPUT_DELAY, 32'h0000_0003, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_5555, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_aaaa, 1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_A_COEF_1,    32'h0000_0001, 1'b0, 16'sh0000, 1'b0}
  };

  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("FAIL %0t: %s", $time, what);
    end
  endfunction

  // Difference equation on one accepted sample: shift the input history,
  // sum all Q.12 products exactly, round half up once, clip to 16 bits,
  // and feed the clipped value back into the output history.
  function automatic void predict_output(input sample_t u, output out_beat_t res);
    longint acc;
    acc = 0;
    for (int i = MAX_DELAY + B_ORDER - 1; i > 0; i--) begin
      u_hist[i] = u_hist[i-1];
    end
    u_hist[0] = u;
    for (int j = 0; j < B_ORDER; j++) begin
      acc += longint'(ff_coef[j]) * longint'(u_hist[int'(dead_time) + j]);
    end
    for (int j = 0; j < A_ORDER; j++) begin
      acc -= longint'(fb_coef[j]) * longint'(y_hist[j]);
    end
    acc += longint'(direct_coef) * longint'(u);
    acc = (acc + ROUND_HALF) >>> FRAC_W;
    res.clip = 1'b1;
    if (acc > longint'(SAMPLE_MAX)) begin
      res.y = SAMPLE_MAX;
    end else if (acc < longint'(SAMPLE_MIN)) begin
      res.y = SAMPLE_MIN;
    end else begin
      res.y    = sample_t'(acc);
      res.clip = 1'b0;
    end
    for (int i = A_ORDER - 1; i > 0; i--) begin
      y_hist[i] = y_hist[i-1];
    end
    y_hist[0] = res.y;
  endfunction

  // APB write: setup cycle, access cycle, then idle with psel low so psel
  // never gets two updates in one step between back-to-back writes.
  task automatic reg_write(input arx_reg_e r, input logic [APB_DW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_A_COEF_1:    fb_coef[0]  = coef_t'(d[15:0]);
      REG_A_COEF_2:    fb_coef[1]  = coef_t'(d[15:0]);
      REG_A_COEF_3:    fb_coef[2]  = coef_t'(d[15:0]);
      REG_B_COEF_0:    ff_coef[0]  = coef_t'(d[15:0]);
      REG_B_COEF_1:    ff_coef[1]  = coef_t'(d[15:0]);
      REG_B_COEF_2:    ff_coef[2]  = coef_t'(d[15:0]);
      REG_INPUT_DELAY: dead_time   = d[DELAY_W-1:0];
      REG_DIRECT_GAIN: direct_coef = coef_t'(d[15:0]);
      default: ;
    endcase
    n_settings++;
    @(negedge clk_i);
  endtask

  // Lower valid, wait for every predicted output, then let the pipe settle.
  // Called at a falling edge, returns at one.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Offer one sample, after a random gap when source gaps are on; predict once the beat is taken.
  // Called at a falling edge, returns at one, valid left high.
  task automatic push_sample(input sample_t s, input logic typed,
                             input sample_t y_t, input logic sat_t);
    int unsigned gap;
    out_beat_t   res;
    gap = (gap_mode == GAP_BOTH || gap_mode == GAP_SRC_ONLY) ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.in_sample <= s;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predict_output(s, res);
    if (typed) begin
      res.y    = y_t;
      res.clip = sat_t;
    end
    pending_outputs = {pending_outputs, res};
    n_in++;
    @(negedge clk_i);
  endtask

  // Output side: random stall per beat when sink gaps are on, one long hold-off on request.
  initial begin : output_sink
    int unsigned gap;
    out_beat_t   want;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
        n_holds++;
      end else if (gap_mode == GAP_BOTH || gap_mode == GAP_SNK_ONLY) begin
        gap = $urandom_range(0, 9);
      end else begin
        gap = 0;
      end
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
      n_out++;
      if (out_bus.saturated === 1'b1) n_clip++;
      if (pending_outputs.size() == 0) begin
        log_failure($sformatf("output beat %0d/%0b with no sample pending",
                              out_bus.out_sample, out_bus.saturated));
      end else begin
        want = pending_outputs.pop_front();
        if (out_bus.out_sample !== want.y || out_bus.saturated !== want.clip) begin
          log_failure($sformatf("beat %0d: out_sample exp %0d got %0d, saturated exp %0b got %0b",
                                n_out, want.y, out_bus.out_sample,
                                want.clip, out_bus.saturated));
        end
      end
      @(negedge clk_i);
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat for %0d cycles, %0d outputs still pending",
             QUIET_LIMIT, pending_outputs.size());
    $display("arx_model_filter: mismatch");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin : stimulus
    logic [31:0]  rnd;
    logic [15:0]  word;
    coef_style_e  style;
    sample_t      smp;
    int unsigned  pick;

    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.in_sample = '0;

    // predictor mirrors the reset values
    fb_coef     = '{A_COEF_1_RST, '0, '0};
    ff_coef     = '{B_COEF_0_RST, '0, '0};
    dead_time   = INPUT_DELAY_RST;
    direct_coef = '0;
    foreach (u_hist[i]) u_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_WRITE) begin
        wait_drained();
        reg_write(dir_rows[n].rsel, dir_rows[n].val);
      end else begin
        push_sample(sample_t'(dir_rows[n].val[15:0]), dir_rows[n].typed,
                    dir_rows[n].y_exp, dir_rows[n].sat_exp);
      end
    end

    // Random phases: new settings while idle, then a stream of samples.
    // Small coefficient sets keep the loop stable so most outputs stay in
    // range; full-range and extreme sets drive it into clipping.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      style = (p % 2 == 0) ? COEF_SMALL : ((p % 4 == 1) ? COEF_FULL : COEF_EXTREME);
      for (int r = 0; r <= int'(REG_DIRECT_GAIN); r++) begin
        rnd = $urandom();
        if (arx_reg_e'(r) == REG_INPUT_DELAY) begin
          word = 16'($urandom_range(0, MAX_DELAY));
        end else begin
          case (style)
            COEF_SMALL: word = 16'($urandom_range(0, 2048) - 1024);
            COEF_FULL:  word = rnd[15:0];
            default: begin
              pick = $urandom_range(0, 2);
              word = (pick == 0) ? COEF_MAX : ((pick == 1) ? COEF_MIN : 16'h0000);
            end
          endcase
        end
        reg_write(arx_reg_e'(r), {rnd[31:16], word});
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 50 == 0) begin
          gap_mode = gap_mode_e'($urandom_range(0, 3));
        end
        // long output hold-off while input keeps coming: fills the pipe
        if (p == HOLD_PHASE && k == 0) begin
          gap_mode = GAP_NONE;
          hold_req = 1'b1;
        end
        // input pause until every output is back
        if (p == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        pick = $urandom_range(0, 9);
        rnd  = $urandom();
        if (pick == 0) begin
          case (rnd[1:0])
            2'd0:    smp = SAMPLE_MAX;
            2'd1:    smp = SAMPLE_MIN;
            2'd2:    smp = '0;
            default: smp = '1;
          endcase
        end else if (pick < 5) begin
          smp = sample_t'($urandom_range(0, 512) - 256);
        end else begin
          smp = sample_t'(rnd[15:0]);
        end
        push_sample(smp, 1'b0, '0, 1'b0);
      end
    end

    wait_drained();
    $display("run: %0d samples in, %0d outputs back, %0d clipped, %0d register writes",
             n_in, n_out, n_clip, n_settings);
    $display("run: %0d long output hold-off(s), %0d failure(s)", n_holds, fail_count);
    if (fail_count == 0) begin
      $display("arx_model_filter: match");
    end else begin
      $display("arx_model_filter: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/arx_pkg.sv
rtl/arx_in_if.sv
rtl/arx_out_if.sv
rtl/arx_model_filter.sv
verif/tb_top.sv
